// File: hdl/direct_mapped_cache_lookup_unit_assert.svh
// Assertion macros shared by the cache lookup RTL.
`ifndef DIRECT_MAPPED_CACHE_LOOKUP_UNIT_ASSERT_SVH
`define DIRECT_MAPPED_CACHE_LOOKUP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge once reset is released.
`define DMCL_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define DMCL_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define DMCL_ASSERT(name, prop, msg)
`define DMCL_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// File: hdl/dmcl_pkg.sv
// Types and constants of the direct-mapped cache lookup unit.
package dmcl_pkg;

   localparam int TAG_W  = 30;
   localparam int WORD_W = 32;
   localparam int CNT_W  = 32;

   // Configuration register indexes.
   localparam logic CSR_CACHE_MODE  = 1'b0;
   localparam logic CSR_INDEX_WIDTH = 1'b1;

   localparam logic       CACHE_MODE_RESET  = 1'b1;
   localparam logic [3:0] INDEX_WIDTH_RESET = 4'd10;

   typedef enum logic [1:0] {
      OUTCOME_HIT       = 2'd0,
      OUTCOME_COLD_MISS = 2'd1,
      OUTCOME_HOT_MISS  = 2'd2,
      OUTCOME_BYPASS    = 2'd3
   } outcome_type;

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [WORD_W-1:0] word;
   } slot_entry_type;

endpackage

// File: hdl/direct_mapped_cache_lookup_unit.sv
// Direct-mapped read cache lookup unit: one request in, one response out.
// The unit takes one request per clock while it is not stalled; a taken request is held in
// the lookup stage, and its response is then registered in the response register. The rate
// is set by the single slot memory, which is read once per request and written on a miss.
// While the response is stalled one further request is held inside, and after that the
// request side stalls. A request to the slot written by the request just ahead is served
// from a forwarding register. After reset a clearing pass zeroes the slot memory, one slot
// per cycle, up to the last slot; requests are stalled during that pass while configuration
// writes are still taken. Configuration may only be written while no request is in flight.
`include "direct_mapped_cache_lookup_unit_assert.svh"

module direct_mapped_cache_lookup_unit
   import dmcl_pkg::*;
#(
   parameter int MAX_SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [3:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_address,
   input  logic [31:0] req_memory_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [1:0]  rsp_outcome,
   output logic [31:0] rsp_reference_total,
   output logic [31:0] rsp_hit_total,
   output logic [31:0] rsp_miss_total,
   output logic [31:0] rsp_cold_miss_total,
   output logic [31:0] rsp_hot_miss_total
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   // Largest index width whose slot count still fits in the memory.
   localparam int MAX_W = $clog2(MAX_SLOTS + 1) - 1;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_SLOTS - 1);

   slot_entry_type slot_mem [MAX_SLOTS];

   logic              cache_mode_ff;
   logic [3:0]        index_width_ff;

   logic              clear_active_ff;
   logic [IDX_W-1:0]  clear_idx_ff;

   logic              s1_valid_ff;
   logic              s1_cached_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [TAG_W-1:0]  s1_tag_ff;
   logic [WORD_W-1:0] s1_word_ff;
   slot_entry_type    rd_entry_ff;
   logic              fwd_ff;
   slot_entry_type    fwd_entry_ff;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_read_data_ff;
   outcome_type       rsp_outcome_ff;
   logic [CNT_W-1:0]  lookups_ff;
   logic [CNT_W-1:0]  hits_ff;
   logic [CNT_W-1:0]  misses_ff;
   logic [CNT_W-1:0]  cold_misses_ff;
   logic [CNT_W-1:0]  hot_misses_ff;
   logic [CNT_W-1:0]  lookups_in;
   logic [CNT_W-1:0]  hits_in;
   logic [CNT_W-1:0]  misses_in;
   logic [CNT_W-1:0]  cold_misses_in;
   logic [CNT_W-1:0]  hot_misses_in;
   logic [WORD_W-1:0] read_data_in;
   outcome_type       outcome_in;

   logic              req_accept;
   logic              s1_go;
   logic [3:0]        eff_w;
   logic [31:0]       idx_mask;
   logic [31:0]       idx_full;
   logic [31:0]       tag_full;
   logic [IDX_W-1:0]  req_idx;
   slot_entry_type    s1_entry;
   logic              s1_hit;
   logic              wb_en;
   slot_entry_type    wb_entry;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   slot_entry_type    mem_wdata;

   // Request side: index and tag under the current index width.
   always_comb begin
      if (int'(index_width_ff) > MAX_W) begin
         eff_w = 4'(MAX_W);
      end else begin
         eff_w = index_width_ff;
      end
      idx_mask = (32'd1 << eff_w) - 32'd1;
      idx_full = {2'b00, req_address[31:2]} & idx_mask;
      req_idx  = idx_full[IDX_W-1:0];
      tag_full = req_address >> ({1'b0, eff_w} + 5'd2);
   end

   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clear_active_ff || (s1_valid_ff && !s1_go);
   assign req_accept = req_valid && !req_stall;

   // The slot read is registered; a write by the request just ahead is forwarded.
   assign s1_entry = fwd_ff ? fwd_entry_ff : rd_entry_ff;
   assign s1_hit   = s1_entry.valid && (s1_entry.tag == s1_tag_ff);
   assign wb_en    = s1_go && s1_cached_ff && !s1_hit;

   always_comb begin
      wb_entry.valid = 1'b1;
      wb_entry.tag   = s1_tag_ff;
      wb_entry.word  = s1_word_ff;
   end

   always_comb begin
      if (clear_active_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_idx_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = wb_en;
         mem_waddr = s1_idx_ff;
         mem_wdata = wb_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         rd_entry_ff <= slot_mem[req_idx];
      end
   end

   // Result and counter update for the request in the second stage.
   always_comb begin
      lookups_in     = lookups_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      cold_misses_in = cold_misses_ff;
      hot_misses_in  = hot_misses_ff;
      read_data_in   = s1_word_ff;
      outcome_in     = OUTCOME_BYPASS;
      if (s1_cached_ff) begin
         lookups_in = lookups_ff + 32'd1;
         if (s1_hit) begin
            hits_in      = hits_ff + 32'd1;
            read_data_in = s1_entry.word;
            outcome_in   = OUTCOME_HIT;
         end else begin
            misses_in = misses_ff + 32'd1;
            if (s1_entry.valid) begin
               hot_misses_in = hot_misses_ff + 32'd1;
               outcome_in    = OUTCOME_HOT_MISS;
            end else begin
               cold_misses_in = cold_misses_ff + 32'd1;
               outcome_in     = OUTCOME_COLD_MISS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_mode_ff   <= CACHE_MODE_RESET;
         index_width_ff  <= INDEX_WIDTH_RESET;
         clear_active_ff <= 1'b1;
         clear_idx_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         lookups_ff      <= '0;
         hits_ff         <= '0;
         misses_ff       <= '0;
         cold_misses_ff  <= '0;
         hot_misses_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CACHE_MODE:  cache_mode_ff  <= csr_write_data[0];
               CSR_INDEX_WIDTH: index_width_ff <= csr_write_data;
               default:         cache_mode_ff  <= cache_mode_ff;
            endcase
         end

         if (clear_active_ff) begin
            clear_idx_ff <= clear_idx_ff + 1'b1;
            if (clear_idx_ff == LAST_SLOT) begin
               clear_active_ff <= 1'b0;
            end
         end

         if (req_accept) begin
            s1_valid_ff  <= 1'b1;
            fwd_ff       <= wb_en && (s1_idx_ff == req_idx);
            s1_cached_ff <= cache_mode_ff;
            s1_idx_ff    <= req_idx;
            s1_tag_ff    <= tag_full[TAG_W-1:0];
            s1_word_ff   <= req_memory_word;
            fwd_entry_ff <= wb_entry;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_go) begin
            rsp_valid_ff     <= 1'b1;
            rsp_read_data_ff <= read_data_in;
            rsp_outcome_ff   <= outcome_in;
            lookups_ff       <= lookups_in;
            hits_ff          <= hits_in;
            misses_ff        <= misses_in;
            cold_misses_ff   <= cold_misses_in;
            hot_misses_ff    <= hot_misses_in;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_read_data_ff;
   assign rsp_outcome         = rsp_outcome_ff;
   assign rsp_reference_total = lookups_ff;
   assign rsp_hit_total       = hits_ff;
   assign rsp_miss_total      = misses_ff;
   assign rsp_cold_miss_total = cold_misses_ff;
   assign rsp_hot_miss_total  = hot_misses_ff;

   `DMCL_ASSERT_ALWAYS(a_no_request_while_clearing, clear_active_ff |-> !req_accept, "request taken during clearing pass")
   `DMCL_ASSERT(a_lookups_split, lookups_ff == hits_ff + misses_ff, "lookup count differs from hits plus misses")
   `DMCL_ASSERT(a_misses_split, misses_ff == cold_misses_ff + hot_misses_ff, "miss count differs from cold plus hot misses")
   `DMCL_ASSERT(a_fill_from_cached_miss, (mem_we && !clear_active_ff) |-> (s1_valid_ff && s1_cached_ff && !s1_hit), "slot written without a cached miss")

endmodule
